// ===== sv/vau_pkg.sv =====
// Package for the 3-vector arithmetic unit: opcodes, payload words, stage
// record and the saturation helper. No dependencies.
package vau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int WIDE      = PROD_W + 4;
    // one quotient bit (and one root bit) per iteration stage
    localparam int ITER      = DATA_W + FRAC_BITS;

    localparam logic [3:0] OP_COPY  = 4'd0;
    localparam logic [3:0] OP_NEG   = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_SUB   = 4'd3;
    localparam logic [3:0] OP_DOT   = 4'd4;
    localparam logic [3:0] OP_SCALE = 4'd5;
    localparam logic [3:0] OP_CROSS = 4'd6;
    localparam logic [3:0] OP_DIV   = 4'd7;
    localparam logic [3:0] OP_MAG   = 4'd8;
    localparam logic [3:0] OP_EQ    = 4'd9;
    localparam logic [3:0] OP_NE    = 4'd10;
    localparam logic [3:0] OP_LT    = 4'd11;
    localparam logic [3:0] OP_GT    = 4'd12;
    localparam logic [3:0] OP_LE    = 4'd13;
    localparam logic [3:0] OP_GE    = 4'd14;

    typedef logic signed [WIDE-1:0] t_wide;

    localparam t_wide SAT_HI = (t_wide'(1) <<< (WORD_BITS - 1)) - t_wide'(1);
    localparam t_wide SAT_LO = -SAT_HI - t_wide'(1);

    typedef struct packed {
        logic [3:0]               op;
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
        logic signed [DATA_W-1:0] b_x;
        logic signed [DATA_W-1:0] b_y;
        logic signed [DATA_W-1:0] b_z;
        logic signed [DATA_W-1:0] scalar_in;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] r_x;
        logic signed [DATA_W-1:0] r_y;
        logic signed [DATA_W-1:0] r_z;
        logic signed [DATA_W-1:0] r_scalar;
        logic                     compare_true;
        logic                     overflow;
        logic                     div_by_zero;
    } t_out;

    // record carried through the divide / square-root stages
    typedef struct packed {
        logic [3:0]                 op;
        logic [DATA_W-1:0]          res_x;
        logic [DATA_W-1:0]          res_y;
        logic [DATA_W-1:0]          res_z;
        logic [DATA_W-1:0]          res_s;
        logic                       cmp;
        logic                       ov;
        logic                       dz;
        logic [2:0][ITER-1:0]       dvd;
        logic [2:0][ITER-1:0]       quo;
        logic [2:0][DATA_W-1:0]     prem;
        logic [2:0]                 neg;
        logic [DATA_W-1:0]          dvs;
        logic [2*ITER-1:0]          rad;
        logic [ITER+1:0]            rem;
        logic [ITER-1:0]            root;
    } t_iter;

    // clamp to the signed WORD_BITS range; msb of the result is the overflow flag
    function automatic logic [DATA_W:0] sat(input t_wide v);
        if (v > SAT_HI) begin
            return {1'b1, SAT_HI[DATA_W-1:0]};
        end else if (v < SAT_LO) begin
            return {1'b1, SAT_LO[DATA_W-1:0]};
        end else begin
            return {1'b0, v[DATA_W-1:0]};
        end
    endfunction

endpackage

// ===== sv/vau_step.sv =====
// One iteration stage: a restoring divide step on three lanes and one
// square-root digit step. Depends on vau_pkg.
module vau_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  vau_pkg::t_iter i_st,
    output logic          o_vld,
    output vau_pkg::t_iter o_st
);
    import vau_pkg::*;

    t_iter             n_st;
    t_iter             r_st;
    logic              r_vld;
    logic [DATA_W:0]   pw;
    logic [DATA_W:0]   pd;
    logic [ITER+3:0]   rw;
    logic [ITER+3:0]   rt;
    logic [ITER+3:0]   rd;

    always_comb begin
        n_st = i_st;
        pw   = '0;
        pd   = '0;
        // divide: bring down one dividend bit, subtract the divisor if it fits
        for (int c = 0; c < 3; c++) begin
            pw = {i_st.prem[c], i_st.dvd[c][ITER-1]};
            pd = pw - {1'b0, i_st.dvs};
            if (pw >= {1'b0, i_st.dvs}) begin
                n_st.prem[c] = pd[DATA_W-1:0];
                n_st.quo[c]  = {i_st.quo[c][ITER-2:0], 1'b1};
            end else begin
                n_st.prem[c] = pw[DATA_W-1:0];
                n_st.quo[c]  = {i_st.quo[c][ITER-2:0], 1'b0};
            end
            n_st.dvd[c] = {i_st.dvd[c][ITER-2:0], 1'b0};
        end
        // square root: bring down two radicand bits, try root*4+1
        rw = {i_st.rem, i_st.rad[2*ITER-1 -: 2]};
        rt = {2'b00, i_st.root, 2'b01};
        rd = rw - rt;
        if (rw >= rt) begin
            n_st.rem  = rd[ITER+1:0];
            n_st.root = {i_st.root[ITER-2:0], 1'b1};
        end else begin
            n_st.rem  = rw[ITER+1:0];
            n_st.root = {i_st.root[ITER-2:0], 1'b0};
        end
        n_st.rad = {i_st.rad[2*ITER-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_vld = r_vld;
    assign o_st  = r_st;

endmodule

// ===== sv/vec3_arithmetic_unit.sv =====
// Every opcode takes the same path, stages 1 to 4, ITER = 32 + FRAC_BITS
// iteration stages (one quotient bit each) and the output stage, from word
// acceptance to o_valid. One word per cycle; a stalled output freezes the
// whole pipe. Reset (synchronous, active low) clears every valid bit.
// Top level of the 3-vector unit; depends on vau_pkg and vau_step.
module vec3_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vau_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output vau_pkg::t_out o_data
);
    import vau_pkg::*;

    // Global advance: every stage moves when the output register is empty
    // or being drained this cycle. Bubbles travel as cleared valid bits.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    logic r_s1_vld;
    t_in  r_s1;

    // ---------------------------------------------------------------
    // Stage 2: six shared 32x32 multipliers. Operands are picked per op:
    // dot, scale and magnitude use three, cross and the ordered compares use six.
    // ---------------------------------------------------------------
    logic signed [DATA_W-1:0] ma [6];
    logic signed [DATA_W-1:0] mb [6];
    logic signed [PROD_W-1:0] n_p [6];
    logic signed [PROD_W-1:0] r_p [6];
    logic                     r_s2_vld;
    t_in                      r_s2;

    always_comb begin
        // default: squares of a and b (magnitude and compares)
        ma[0] = r_s1.a_x; mb[0] = r_s1.a_x;
        ma[1] = r_s1.a_y; mb[1] = r_s1.a_y;
        ma[2] = r_s1.a_z; mb[2] = r_s1.a_z;
        ma[3] = r_s1.b_x; mb[3] = r_s1.b_x;
        ma[4] = r_s1.b_y; mb[4] = r_s1.b_y;
        ma[5] = r_s1.b_z; mb[5] = r_s1.b_z;
        case (r_s1.op)
            OP_DOT: begin
                mb[0] = r_s1.b_x;
                mb[1] = r_s1.b_y;
                mb[2] = r_s1.b_z;
            end
            OP_SCALE: begin
                mb[0] = r_s1.scalar_in;
                mb[1] = r_s1.scalar_in;
                mb[2] = r_s1.scalar_in;
            end
            OP_CROSS: begin
                ma[0] = r_s1.a_y; mb[0] = r_s1.b_z;
                ma[1] = r_s1.b_y; mb[1] = r_s1.a_z;
                ma[2] = r_s1.a_z; mb[2] = r_s1.b_x;
                ma[3] = r_s1.b_z; mb[3] = r_s1.a_x;
                ma[4] = r_s1.a_x; mb[4] = r_s1.b_y;
                ma[5] = r_s1.b_x; mb[5] = r_s1.a_y;
            end
            default: begin
            end
        endcase
        for (int k = 0; k < 6; k++) begin
            n_p[k] = ma[k] * mb[k];
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: exact sums and differences of the products
    // ---------------------------------------------------------------
    t_wide n_sum_a, n_sum_b;
    t_wide n_dif [3];
    t_wide r_sum_a, r_sum_b;
    t_wide r_dif [3];
    t_wide r_prod [3];
    logic  r_s3_vld;
    t_in   r_s3;

    always_comb begin
        n_sum_a = t_wide'(r_p[0]) + t_wide'(r_p[1]) + t_wide'(r_p[2]);
        n_sum_b = t_wide'(r_p[3]) + t_wide'(r_p[4]) + t_wide'(r_p[5]);
        n_dif[0] = t_wide'(r_p[0]) - t_wide'(r_p[1]);
        n_dif[1] = t_wide'(r_p[2]) - t_wide'(r_p[3]);
        n_dif[2] = t_wide'(r_p[4]) - t_wide'(r_p[5]);
    end

    // ---------------------------------------------------------------
    // Stage 4: finish the single-pass ops, set up divide and root
    // ---------------------------------------------------------------
    t_wide             va [3];
    t_wide             vb [3];
    t_wide             vs;
    t_wide             mag_a;
    t_wide             mag_s;
    logic [DATA_W:0]   sv [3];
    logic [DATA_W:0]   ss;
    logic              n_cmp;
    logic              n_dz;
    logic              n_ov;
    t_iter             n_it;
    logic              r_s4_vld;
    t_iter             r_s4;

    always_comb begin
        va[0] = t_wide'(r_s3.a_x);
        va[1] = t_wide'(r_s3.a_y);
        va[2] = t_wide'(r_s3.a_z);
        vb[0] = t_wide'(r_s3.b_x);
        vb[1] = t_wide'(r_s3.b_y);
        vb[2] = t_wide'(r_s3.b_z);
        vs    = t_wide'(r_s3.scalar_in);
        mag_a = '0;
        mag_s = (vs < 0) ? -vs : vs;
        for (int i = 0; i < 3; i++) begin
            sv[i] = '0;
        end
        ss    = '0;
        n_cmp = 1'b0;
        n_dz  = 1'b0;

        case (r_s3.op)
            OP_COPY: begin
                for (int i = 0; i < 3; i++) sv[i] = sat(va[i]);
            end
            OP_NEG: begin
                for (int i = 0; i < 3; i++) sv[i] = sat(-va[i]);
            end
            OP_ADD: begin
                for (int i = 0; i < 3; i++) sv[i] = sat(va[i] + vb[i]);
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++) sv[i] = sat(va[i] - vb[i]);
            end
            OP_DOT: begin
                ss = sat(r_sum_a >>> FRAC_BITS);
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) sv[i] = sat(r_prod[i] >>> FRAC_BITS);
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) sv[i] = sat(r_dif[i] >>> FRAC_BITS);
            end
            OP_DIV: begin
                // zero divisor: clamp by sign of the dividend, no overflow flag
                if (vs == 0) begin
                    n_dz = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        if (va[i] > 0) begin
                            sv[i] = {1'b0, SAT_HI[DATA_W-1:0]};
                        end else if (va[i] < 0) begin
                            sv[i] = {1'b0, SAT_LO[DATA_W-1:0]};
                        end else begin
                            sv[i] = '0;
                        end
                    end
                end
            end
            OP_EQ: n_cmp = (va[0] == vb[0]) && (va[1] == vb[1]) && (va[2] == vb[2]);
            OP_NE: n_cmp = !((va[0] == vb[0]) && (va[1] == vb[1]) && (va[2] == vb[2]));
            OP_LT: n_cmp = r_sum_a <  r_sum_b;
            OP_GT: n_cmp = r_sum_a >  r_sum_b;
            OP_LE: n_cmp = r_sum_a <= r_sum_b;
            OP_GE: n_cmp = r_sum_a >= r_sum_b;
            default: begin
            end
        endcase

        n_ov = sv[0][DATA_W] | sv[1][DATA_W] | sv[2][DATA_W] | ss[DATA_W];

        n_it       = '0;
        n_it.op    = r_s3.op;
        n_it.res_x = sv[0][DATA_W-1:0];
        n_it.res_y = sv[1][DATA_W-1:0];
        n_it.res_z = sv[2][DATA_W-1:0];
        n_it.res_s = ss[DATA_W-1:0];
        n_it.cmp   = n_cmp;
        n_it.ov    = n_ov;
        n_it.dz    = n_dz;
        // divider lanes: |a| << FRAC_BITS over |scalar|, sign applied at the end
        for (int i = 0; i < 3; i++) begin
            mag_a = (va[i] < 0) ? -va[i] : va[i];
            n_it.dvd[i] = mag_a[ITER-1:0] << FRAC_BITS;
            n_it.neg[i] = va[i][WIDE-1] ^ vs[WIDE-1];
        end
        n_it.dvs = mag_s[DATA_W-1:0];
        // root of |a|^2, radicand right-aligned in the digit register
        n_it.rad = (2*ITER)'(r_sum_a[PROD_W-1:0]);
    end

    // ---------------------------------------------------------------
    // Pipeline registers, stages 1 to 4
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= i_data;
            r_s2 <= r_s1;
            for (int k = 0; k < 6; k++) begin
                r_p[k] <= n_p[k];
            end
            r_s3    <= r_s2;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            for (int i = 0; i < 3; i++) begin
                r_dif[i]  <= n_dif[i];
                r_prod[i] <= t_wide'(r_p[i]);
            end
            r_s4 <= n_it;
        end
    end

    // ---------------------------------------------------------------
    // Iteration chain: ITER identical stages, one quotient bit per lane and
    // one root bit per stage.
    // ---------------------------------------------------------------
    logic  w_vld [ITER+1];
    t_iter w_st  [ITER+1];

    assign w_vld[0] = r_s4_vld;
    assign w_st[0]  = r_s4;

    for (genvar g = 0; g < ITER; g++) begin : g_step
        vau_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (w_vld[g]),
            .i_st    (w_st[g]),
            .o_vld   (w_vld[g+1]),
            .o_st    (w_st[g+1])
        );
    end

    // ---------------------------------------------------------------
    // Output stage: sign and clamp quotient or root, then hold the word
    // ---------------------------------------------------------------
    t_iter           lst;
    t_wide           qv;
    logic [DATA_W:0] qs [3];
    logic [DATA_W:0] rsq;
    t_out            n_out;
    t_out            r_out;
    logic            r_out_vld;

    always_comb begin
        lst = w_st[ITER];
        qv  = '0;
        for (int c = 0; c < 3; c++) begin
            qv    = t_wide'(lst.quo[c]);
            qs[c] = sat(lst.neg[c] ? -qv : qv);
        end
        rsq = sat(t_wide'(lst.root));

        n_out.r_x          = lst.res_x;
        n_out.r_y          = lst.res_y;
        n_out.r_z          = lst.res_z;
        n_out.r_scalar     = lst.res_s;
        n_out.compare_true = lst.cmp;
        n_out.overflow     = lst.ov;
        n_out.div_by_zero  = lst.dz;
        if (lst.op == OP_DIV && !lst.dz) begin
            n_out.r_x      = qs[0][DATA_W-1:0];
            n_out.r_y      = qs[1][DATA_W-1:0];
            n_out.r_z      = qs[2][DATA_W-1:0];
            n_out.overflow = qs[0][DATA_W] | qs[1][DATA_W] | qs[2][DATA_W];
        end
        if (lst.op == OP_MAG) begin
            n_out.r_scalar = rsq[DATA_W-1:0];
            n_out.overflow = rsq[DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= w_vld[ITER];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ===== sv/vau_checker.sv =====
// Port-level checks for the 3-vector unit and the bind that attaches them.
// Depends on vau_pkg and vec3_arithmetic_unit.
module vau_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input vau_pkg::t_out o_data
);
    import vau_pkg::*;

    // a held output word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // an empty output register never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.div_by_zero |-> !o_data.overflow && !o_data.compare_true)
        else $error("divide by zero with other flags");

    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.compare_true |-> o_data.r_x == 0 && o_data.r_y == 0
            && o_data.r_z == 0 && o_data.r_scalar == 0 && !o_data.overflow)
        else $error("compare word carries data");

endmodule

bind vec3_arithmetic_unit vau_checker u_vau_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
